// File: rtl/core/ilse_pkg.sv
package ilse_pkg;

	// width of lattice sizes and site indexes, covers sizes up to 511
	localparam int SZ_W = 9;

	typedef enum logic [1:0] {
		CMD_PROBE,
		CMD_FLIP,
		CMD_WRITE,
		CMD_FILL
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD_DN,
		ST_RD_MID,
		ST_CALC,
		ST_FILL_RD,
		ST_FILL_WR,
		ST_FILL_TOT,
		ST_DONE
	} st_t;

	typedef struct packed {
		logic        [6:0] rows;
		logic        [6:0] cols;
		logic signed [7:0] coupling;
	} cfg_t;

	typedef struct packed {
		logic signed [11:0] delta_energy;
		logic               site_spin;
		logic signed [21:0] total_energy;
		logic signed [13:0] magnetization;
		logic               bad_site;
	} res_t;

	localparam logic        [6:0]  RST_ROWS     = 7'd64;
	localparam logic        [6:0]  RST_COLS     = 7'd64;
	localparam logic signed [7:0]  RST_COUPLING = 8'sd1;
	localparam logic signed [21:0] RST_ENERGY   = -22'sd8192;
	localparam logic signed [13:0] RST_MAGNET   = 14'sd4096;

	// size in use: zero acts as one, above the maximum acts as the maximum
	function automatic logic [SZ_W-1:0] eff_size(input logic [6:0] raw,
		input logic [SZ_W-1:0] lim);
		logic [SZ_W-1:0] r9;
		r9 = SZ_W'(raw);
		if (raw == 7'd0) begin
			return SZ_W'(1);
		end else if (r9 > lim) begin
			return lim;
		end
		return r9;
	endfunction

	function automatic logic [SZ_W-1:0] wrap_prev(input logic [SZ_W-1:0] idx,
		input logic [SZ_W-1:0] size);
		return (idx == '0) ? size - SZ_W'(1) : idx - SZ_W'(1);
	endfunction

	function automatic logic [SZ_W-1:0] wrap_next(input logic [SZ_W-1:0] idx,
		input logic [SZ_W-1:0] size);
		return (idx + SZ_W'(1) == size) ? '0 : idx + SZ_W'(1);
	endfunction

endpackage

// File: rtl/core/ilse_spin_mem.sv
module ilse_spin_mem #(
	parameter int MAX_ROWS = 64,
	parameter int MAX_COLS = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [$clog2(MAX_ROWS)-1:0] rd_addr,
	output logic [MAX_COLS-1:0]         rd_row,
	input  logic                        we,
	input  logic [$clog2(MAX_ROWS)-1:0] wr_addr,
	input  logic [MAX_COLS-1:0]         wr_row
);

	// one word per lattice row
	logic [MAX_COLS-1:0] mem [MAX_ROWS];
	logic [MAX_ROWS-1:0] vld_q;
	logic [MAX_COLS-1:0] rdata_s1;
	logic                rvld_s1;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_row;
		end
		rdata_s1 <= mem[rd_addr];
	end

	// a row never written reads as all spins up
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q   <= '0;
			rvld_s1 <= 1'b0;
		end else begin
			if (we) begin
				vld_q[wr_addr] <= 1'b1;
			end
			rvld_s1 <= vld_q[rd_addr];
		end
	end

	assign rd_row = rvld_s1 ? rdata_s1 : '1;

endmodule

// File: rtl/core/ilse_apb_regs.sv
module ilse_apb_regs (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [3:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	output ilse_pkg::cfg_t      cfg
);

	localparam logic [1:0] REG_ROWS     = 2'd0;
	localparam logic [1:0] REG_COLS     = 2'd1;
	localparam logic [1:0] REG_COUPLING = 2'd2;

	ilse_pkg::cfg_t cfg_q;
	logic           wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rows     <= ilse_pkg::RST_ROWS;
			cfg_q.cols     <= ilse_pkg::RST_COLS;
			cfg_q.coupling <= ilse_pkg::RST_COUPLING;
		end else if (wr_en) begin
			case (paddr[3:2])
				REG_ROWS:     cfg_q.rows     <= pwdata[6:0];
				REG_COLS:     cfg_q.cols     <= pwdata[6:0];
				REG_COUPLING: cfg_q.coupling <= pwdata[7:0];
				default:      ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_ROWS:     prdata = {25'd0, cfg_q.rows};
			REG_COLS:     prdata = {25'd0, cfg_q.cols};
			REG_COUPLING: prdata = {24'd0, cfg_q.coupling};
			default:      prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

// File: rtl/core/ilse_seq.sv
module ilse_seq #(
	parameter int MAX_ROWS = 64,
	parameter int MAX_COLS = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  ilse_pkg::cfg_t              cfg,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  ilse_pkg::cmd_t              in_cmd,
	input  logic [5:0]                  in_row,
	input  logic [5:0]                  in_col,
	input  logic                        in_spin,
	output logic [$clog2(MAX_ROWS)-1:0] rd_addr,
	input  logic [MAX_COLS-1:0]         rd_row,
	output logic                        we,
	output logic [$clog2(MAX_ROWS)-1:0] wr_addr,
	output logic [MAX_COLS-1:0]         wr_row,
	output logic                        res_valid,
	input  logic                        res_ready,
	output ilse_pkg::res_t              res
);

	localparam int SZW = ilse_pkg::SZ_W;
	localparam int RW  = $clog2(MAX_ROWS);
	localparam int CW  = $clog2(MAX_COLS);

	ilse_pkg::st_t st_q, st_d;

	ilse_pkg::cmd_t     cmd_q;
	logic [SZW-1:0]     r_q, c_q;
	logic               sv_q;
	logic               up_bit_q, dn_bit_q;
	logic signed [11:0] de_q;
	logic               site_q, bad_q, flip_q;
	logic [RW-1:0]      ptr_q;
	logic [16:0]        nm_q;
	logic signed [21:0] energy_q;
	logic signed [13:0] magnet_q;

	logic [SZW-1:0]      n, m, in_r9, in_up, dn;
	logic [CW-1:0]       cidx, lfidx, rtidx;
	logic                s_bit, bad_c, flip_c, fill_last;
	logic [2:0]          k;
	logic signed [4:0]   ssum, sprod;
	logic signed [12:0]  j_x, ss_x, prod;
	logic signed [11:0]  de_c;
	logic signed [25:0]  fill_p;
	logic signed [21:0]  fill_e;
	logic [MAX_COLS-1:0] colmask, tog;

	assign n     = ilse_pkg::eff_size(cfg.rows, SZW'(MAX_ROWS));
	assign m     = ilse_pkg::eff_size(cfg.cols, SZW'(MAX_COLS));
	assign in_r9 = SZW'(in_row);
	assign in_up = ilse_pkg::wrap_prev(in_r9, n);
	assign dn    = ilse_pkg::wrap_next(r_q, n);
	assign cidx  = c_q[CW-1:0];
	assign lfidx = CW'(ilse_pkg::wrap_prev(c_q, m));
	assign rtidx = CW'(ilse_pkg::wrap_next(c_q, m));

	// neighbour sum 2k-4 from the count of up neighbours, then times s and J
	assign s_bit = rd_row[cidx];
	assign k     = 3'(up_bit_q) + 3'(dn_bit_q) + 3'(rd_row[lfidx]) + 3'(rd_row[rtidx]);
	assign ssum  = $signed({1'b0, k, 1'b0}) - 5'sd4;
	assign sprod = s_bit ? ssum : -ssum;
	assign j_x   = 13'(cfg.coupling);
	assign ss_x  = 13'(sprod);
	assign prod  = j_x * ss_x;
	assign de_c  = {prod[10:0], 1'b0};

	assign bad_c  = (r_q >= n) || (c_q >= m);
	assign flip_c = !bad_c && ((cmd_q == ilse_pkg::CMD_FLIP) ||
		((cmd_q == ilse_pkg::CMD_WRITE) && (sv_q != s_bit)));

	assign fill_last = (SZW'(ptr_q) == n - SZW'(1));
	assign fill_p    = 26'(cfg.coupling) * $signed({9'd0, nm_q});
	assign fill_e    = -{fill_p[20:0], 1'b0};

	always_comb begin
		for (int b = 0; b < MAX_COLS; b++) begin
			colmask[b] = (SZW'(b) < m);
		end
	end

	assign tog = {{(MAX_COLS-1){1'b0}}, 1'b1} << cidx;

	// next state
	always_comb begin
		st_d = st_q;
		case (st_q)
			ilse_pkg::ST_IDLE: begin
				if (in_valid) begin
					st_d = (in_cmd == ilse_pkg::CMD_FILL) ? ilse_pkg::ST_FILL_RD
						: ilse_pkg::ST_RD_DN;
				end
			end
			ilse_pkg::ST_RD_DN:     st_d = ilse_pkg::ST_RD_MID;
			ilse_pkg::ST_RD_MID:    st_d = ilse_pkg::ST_CALC;
			ilse_pkg::ST_CALC:      st_d = ilse_pkg::ST_DONE;
			ilse_pkg::ST_FILL_RD:   st_d = ilse_pkg::ST_FILL_WR;
			ilse_pkg::ST_FILL_WR: begin
				st_d = fill_last ? ilse_pkg::ST_FILL_TOT : ilse_pkg::ST_FILL_RD;
			end
			ilse_pkg::ST_FILL_TOT:  st_d = ilse_pkg::ST_DONE;
			ilse_pkg::ST_DONE: begin
				if (res_ready) begin
					st_d = ilse_pkg::ST_IDLE;
				end
			end
			default:                st_d = ilse_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_ready  = 1'b0;
		res_valid = 1'b0;
		rd_addr   = '0;
		we        = 1'b0;
		wr_addr   = r_q[RW-1:0];
		wr_row    = rd_row ^ tog;
		case (st_q)
			ilse_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				rd_addr  = in_up[RW-1:0];
			end
			ilse_pkg::ST_RD_DN:  rd_addr = dn[RW-1:0];
			ilse_pkg::ST_RD_MID: rd_addr = r_q[RW-1:0];
			ilse_pkg::ST_CALC:   we = flip_c;
			ilse_pkg::ST_FILL_RD: rd_addr = ptr_q;
			ilse_pkg::ST_FILL_WR: begin
				we      = 1'b1;
				wr_addr = ptr_q;
				wr_row  = rd_row | colmask;
			end
			ilse_pkg::ST_DONE:   res_valid = 1'b1;
			default:             ;
		endcase
	end

	always_comb begin
		res.delta_energy  = de_q;
		res.site_spin     = site_q;
		res.bad_site      = bad_q;
		res.total_energy  = flip_q ? energy_q + 22'(de_q) : energy_q;
		res.magnetization = flip_q ? (site_q ? magnet_q - 14'sd2 : magnet_q + 14'sd2)
			: magnet_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ilse_pkg::ST_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			energy_q <= ilse_pkg::RST_ENERGY;
			magnet_q <= ilse_pkg::RST_MAGNET;
		end else if (st_q == ilse_pkg::ST_FILL_TOT) begin
			energy_q <= fill_e;
			magnet_q <= nm_q[13:0];
		end else if (st_q == ilse_pkg::ST_DONE && res_ready) begin
			energy_q <= res.total_energy;
			magnet_q <= res.magnetization;
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			ilse_pkg::ST_IDLE: begin
				if (in_valid) begin
					cmd_q <= in_cmd;
					r_q   <= in_r9;
					c_q   <= SZW'(in_col);
					sv_q  <= in_spin;
					ptr_q <= '0;
					nm_q  <= {8'd0, n} * {8'd0, m};
				end
			end
			ilse_pkg::ST_RD_DN:  up_bit_q <= rd_row[cidx];
			ilse_pkg::ST_RD_MID: dn_bit_q <= rd_row[cidx];
			ilse_pkg::ST_CALC: begin
				de_q   <= bad_c ? 12'sd0 : de_c;
				site_q <= bad_c ? 1'b0 : s_bit;
				bad_q  <= bad_c;
				flip_q <= flip_c;
			end
			ilse_pkg::ST_FILL_WR: begin
				if (!fill_last) begin
					ptr_q <= ptr_q + RW'(1);
				end
			end
			ilse_pkg::ST_FILL_TOT: begin
				de_q   <= 12'sd0;
				site_q <= 1'b0;
				bad_q  <= 1'b0;
				flip_q <= 1'b0;
			end
			default: ;
		endcase
	end

endmodule

// File: rtl/core/ising_lattice_spin_engine.sv
// 2D Ising lattice engine with wrap-around on both axes. Spins sit in one
// synchronous memory, one word per lattice row, read through a single port.
// Each probe, flip or write transfer reads the row above, the row below and
// the addressed row in turn, then computes the flip energy change
// 2*J*s*(sum of four neighbours) and writes the row back if the spin changes,
// keeping the running total energy and magnetization. The three row reads on
// the one memory port set the pace of such a command, and no new command is
// taken until its result has gone to the output register. A fill command walks
// the rows in use with a read and a write per row and loads the totals in closed
// form. The result sits in an output register, so an item can be accepted while
// the previous result waits to be taken. There is no clearing pass: a row never
// written reads as all spins up. Configuration (rows, columns, coupling at byte
// addresses 0, 4, 8) is to be written only while idle; the block itself does
// not enforce this. Follow a size change with a fill.
module ising_lattice_spin_engine #(
	parameter int MAX_ROWS = 64,
	parameter int MAX_COLS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // row[5:0], col[11:6], spin_value[12], zero fill
	input  logic [1:0]  s_tuser,  // cmd[1:0]
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,  // delta_energy[11:0], site_spin[12],
	                              // total_energy[34:13], magnetization[48:35], zero fill
	output logic [0:0]  m_tuser,  // bad_site[0]
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int RW = $clog2(MAX_ROWS);

	ilse_pkg::cfg_t cfg;
	ilse_pkg::res_t res, res_q;
	logic           res_valid, res_ready;
	logic           m_tvalid_q;

	// memory port
	logic [RW-1:0]       rd_addr, wr_addr;
	logic [MAX_COLS-1:0] rd_row, wr_row;
	logic                we;

	ilse_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	ilse_spin_mem #(
		.MAX_ROWS (MAX_ROWS),
		.MAX_COLS (MAX_COLS)
	) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_addr (rd_addr),
		.rd_row  (rd_row),
		.we      (we),
		.wr_addr (wr_addr),
		.wr_row  (wr_row)
	);

	ilse_seq #(
		.MAX_ROWS (MAX_ROWS),
		.MAX_COLS (MAX_COLS)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_cmd    (ilse_pkg::cmd_t'(s_tuser)),
		.in_row    (s_tdata[5:0]),
		.in_col    (s_tdata[11:6]),
		.in_spin   (s_tdata[12]),
		.rd_addr   (rd_addr),
		.rd_row    (rd_row),
		.we        (we),
		.wr_addr   (wr_addr),
		.wr_row    (wr_row),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// output register: takes a new result when empty or being drained
	assign res_ready = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_ready) begin
			m_tvalid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			res_q <= res;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {7'd0, res_q.magnetization, res_q.total_energy,
		res_q.site_spin, res_q.delta_energy};
	assign m_tuser  = res_q.bad_site;

endmodule

// File: rtl/core/ilse_checker.sv
module ilse_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [55:0] m_tdata,
	input logic [0:0]  m_tuser
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// one command at a time: busy right after an input transfer
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while a command is in flight");

	// a bad site reports no energy change and no spin
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata[12:0] == 13'd0)
		else $error("bad site result with nonzero energy change or spin");

	// flip energy is always even
	a_de_even: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !m_tdata[0])
		else $error("odd energy change");

	// a result never shows up right after an input transfer
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> !$past(s_tvalid && s_tready))
		else $error("result too soon after input transfer");

endmodule

bind ising_lattice_spin_engine ilse_checker u_ilse_checker (.*);

// File: sim/ising_lattice_spin_engine_test.sv
`timescale 1ns / 100ps

module ising_lattice_spin_engine_test;

	// lattice bounds of the instance below
	localparam int LAT_ROWS = 64;
	localparam int LAT_COLS = 64;

	// configuration byte addresses
	localparam logic [3:0] ADDR_ROWS     = 4'h0;
	localparam logic [3:0] ADDR_COLS     = 4'h4;
	localparam logic [3:0] ADDR_COUPLING = 4'h8;

	// one command as it travels on the input stream
	typedef struct {
		ilse_pkg::cmd_t cmd;
		logic [5:0]     row;
		logic [5:0]     col;
		logic           spin_value;
	} lattice_cmd_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [55:0] m_tdata;
	logic [0:0]  m_tuser;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	ising_lattice_spin_engine #(
		.MAX_ROWS(LAT_ROWS),
		.MAX_COLS(LAT_COLS)
	) DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// 2 ns clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// predictor state: spins, running totals and register copies
	bit                 spin_up [LAT_ROWS][LAT_COLS];
	logic signed [21:0] energy_sum = ilse_pkg::RST_ENERGY;
	logic signed [13:0] magnet_sum = ilse_pkg::RST_MAGNET;
	logic [6:0]         rows_reg = ilse_pkg::RST_ROWS;
	logic [6:0]         cols_reg = ilse_pkg::RST_COLS;
	logic signed [7:0]  coupling_reg = ilse_pkg::RST_COUPLING;

	lattice_cmd_t     pending_cmds[$];   // commands not yet offered to the block
	ilse_pkg::res_t   due_results[$];    // predicted results, oldest first
	lattice_cmd_t     drive_cmd;         // command currently on the input stream
	int               send_idle_pct = 0;
	int               recv_stall_pct = 0;
	int               mismatch_count = 0;

	// rows or columns in use: zero acts as one, clamp at the bound
	function automatic int size_in_use(input logic [6:0] raw, input int bound);
		if (raw == 7'd0) begin
			return 1;
		end
		return (int'(raw) > bound) ? bound : int'(raw);
	endfunction

	function automatic int spin_sign(input int r, input int c);
		return spin_up[r][c] ? 1 : -1;
	endfunction

	// apply one command to the predicted lattice, return the result it causes
	function automatic ilse_pkg::res_t apply_lattice_cmd(input lattice_cmd_t it);
		ilse_pkg::res_t r;
		int   n, m, j, rr, cc, up_r, dn_r, lf_c, rt_c, s, nsum, de;
		bit   do_flip;
		r = '0;
		n = size_in_use(rows_reg, LAT_ROWS);
		m = size_in_use(cols_reg, LAT_COLS);
		j = int'(coupling_reg);
		rr = int'(it.row);
		cc = int'(it.col);
		if (it.cmd == ilse_pkg::CMD_FILL) begin
			// address ignored, every in-use spin up, totals in closed form
			for (int a = 0; a < n; a++) begin
				for (int b = 0; b < m; b++) begin
					spin_up[a][b] = 1'b1;
				end
			end
			energy_sum = 22'(-2 * j * n * m);
			magnet_sum = 14'(n * m);
		end else if (rr >= n || cc >= m) begin
			r.bad_site = 1'b1;
		end else begin
			// wrap-around neighbours
			up_r = (rr == 0) ? n - 1 : rr - 1;
			dn_r = (rr + 1 == n) ? 0 : rr + 1;
			lf_c = (cc == 0) ? m - 1 : cc - 1;
			rt_c = (cc + 1 == m) ? 0 : cc + 1;
			s = spin_sign(rr, cc);
			nsum = spin_sign(up_r, cc) + spin_sign(dn_r, cc)
				+ spin_sign(rr, lf_c) + spin_sign(rr, rt_c);
			de = 2 * j * s * nsum;
			r.delta_energy = 12'(de);
			r.site_spin = spin_up[rr][cc];
			if (it.cmd == ilse_pkg::CMD_FLIP) begin
				do_flip = 1'b1;
			end else if (it.cmd == ilse_pkg::CMD_WRITE) begin
				do_flip = (it.spin_value != spin_up[rr][cc]);
			end else begin
				do_flip = 1'b0;
			end
			if (do_flip) begin
				spin_up[rr][cc] = !spin_up[rr][cc];
				// both totals wrap at their widths
				energy_sum = 22'(int'(energy_sum) + de);
				magnet_sum = 14'(int'(magnet_sum) - 2 * s);
			end
		end
		r.total_energy = energy_sum;
		r.magnetization = magnet_sum;
		return r;
	endfunction

	// input side: offer queued commands, idling at random
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			// transfer taken at this edge: predict its result now
			if (s_tvalid && s_tready) begin
				due_results.push_back(apply_lattice_cmd(drive_cmd));
			end
			if (!s_tvalid || s_tready) begin
				if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					drive_cmd = pending_cmds.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {3'b000, drive_cmd.spin_value, drive_cmd.col, drive_cmd.row};
					s_tuser <= drive_cmd.cmd;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// output side: random back-pressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			mismatch_count++;
			if (mismatch_count <= 10) begin
				$display("%0t: %s mismatch, expected %0d, got %0d", $realtime, name, want, got);
			end
		end
	endtask

	// compare each result transfer against the oldest prediction
	always @(posedge clk) begin : result_check
		ilse_pkg::res_t due;
		if (arst_n && m_tvalid && m_tready) begin
			if (due_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10) begin
					$display("%0t: result transfer with none expected, data %h user %b",
						$realtime, m_tdata, m_tuser);
				end
			end else begin
				due = due_results.pop_front();
				check_field("delta_energy", int'(due.delta_energy),
					int'($signed(m_tdata[11:0])));
				check_field("site_spin", int'(due.site_spin), int'(m_tdata[12]));
				check_field("total_energy", int'(due.total_energy),
					int'($signed(m_tdata[34:13])));
				check_field("magnetization", int'(due.magnetization),
					int'($signed(m_tdata[48:35])));
				check_field("bad_site", int'(due.bad_site), int'(m_tuser[0]));
			end
		end
	end

	task automatic queue_cmd(input ilse_pkg::cmd_t c, input int r, input int col, input bit v);
		lattice_cmd_t it;
		it.cmd = c;
		it.row = 6'(r);
		it.col = 6'(col);
		it.spin_value = v;
		pending_cmds.push_back(it);
	endtask

	// wait until every command is sent and every result has come back
	task automatic drain();
		do begin
			@(negedge clk);
		end while (pending_cmds.size() != 0 || s_tvalid || due_results.size() != 0);
	endtask

	// setup then access cycle, register takes the value at the access edge
	task automatic write_reg(input logic [3:0] addr, input logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		case (addr)
			ADDR_ROWS: rows_reg = value[6:0];
			ADDR_COLS: cols_reg = value[6:0];
			ADDR_COUPLING: coupling_reg = value[7:0];
			default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic reconfigure(input int rows, input int cols, input int coupling);
		// let the block settle after the last result
		repeat (8) @(negedge clk);
		write_reg(ADDR_ROWS, {25'd0, 7'(rows)});
		write_reg(ADDR_COLS, {25'd0, 7'(cols)});
		write_reg(ADDR_COUPLING, {24'd0, 8'(coupling)});
	endtask

	task automatic set_pace(input int idle_pct, input int stall_pct);
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
	endtask

	// site index biased toward the wrap edges, sometimes anywhere in 0..63
	function automatic int pick_site(input int size);
		int p;
		p = $urandom_range(99);
		if (p < 12) begin
			return $urandom_range(63);
		end else if (p < 27) begin
			return 0;
		end else if (p < 42) begin
			return size - 1;
		end
		return $urandom_range(size - 1);
	endfunction

	// mostly in-lattice probes, flips and writes, a few fills
	task automatic run_random(input int count);
		lattice_cmd_t it;
		int           n, m, p;
		n = size_in_use(rows_reg, LAT_ROWS);
		m = size_in_use(cols_reg, LAT_COLS);
		repeat (count) begin
			p = $urandom_range(99);
			if (p < 6) begin
				it.cmd = ilse_pkg::CMD_FILL;
			end else if (p < 36) begin
				it.cmd = ilse_pkg::CMD_PROBE;
			end else if (p < 68) begin
				it.cmd = ilse_pkg::CMD_FLIP;
			end else begin
				it.cmd = ilse_pkg::CMD_WRITE;
			end
			it.row = 6'(pick_site(n));
			it.col = 6'(pick_site(m));
			it.spin_value = 1'($urandom_range(1));
			pending_cmds.push_back(it);
		end
		drain();
	endtask

	initial begin
		foreach (spin_up[a, b]) begin
			spin_up[a][b] = 1'b1;
		end
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset size 64x64, J = 1, no idling
		set_pace(0, 0);
		queue_cmd(ilse_pkg::CMD_PROBE, 0, 0, 1'b0);
		queue_cmd(ilse_pkg::CMD_PROBE, 63, 63, 1'b1);
		queue_cmd(ilse_pkg::CMD_FLIP, 0, 0, 1'b0);
		queue_cmd(ilse_pkg::CMD_PROBE, 0, 1, 1'b0);     // neighbour of the flipped site
		queue_cmd(ilse_pkg::CMD_FLIP, 63, 63, 1'b1);
		queue_cmd(ilse_pkg::CMD_WRITE, 0, 63, 1'b0);
		queue_cmd(ilse_pkg::CMD_WRITE, 0, 63, 1'b0);    // same spin again, no change
		queue_cmd(ilse_pkg::CMD_WRITE, 63, 0, 1'b1);    // already up
		queue_cmd(ilse_pkg::CMD_WRITE, 0, 0, 1'b1);
		queue_cmd(ilse_pkg::CMD_FLIP, 42, 21, 1'b0);
		queue_cmd(ilse_pkg::CMD_PROBE, 21, 42, 1'b1);
		queue_cmd(ilse_pkg::CMD_FILL, 63, 63, 1'b1);    // address must be ignored
		queue_cmd(ilse_pkg::CMD_PROBE, 0, 0, 1'b1);
		run_random(300);

		// 3x3 lattice, most negative coupling, sender mostly idle
		reconfigure(3, 3, -128);
		set_pace(81, 0);
		queue_cmd(ilse_pkg::CMD_PROBE, 1, 1, 1'b0);     // totals still from the old size
		queue_cmd(ilse_pkg::CMD_FILL, 63, 0, 1'b1);
		queue_cmd(ilse_pkg::CMD_PROBE, 3, 0, 1'b0);     // row out of range
		queue_cmd(ilse_pkg::CMD_FLIP, 0, 3, 1'b0);      // column out of range
		queue_cmd(ilse_pkg::CMD_WRITE, 63, 63, 1'b0);
		queue_cmd(ilse_pkg::CMD_FLIP, 2, 2, 1'b0);
		queue_cmd(ilse_pkg::CMD_WRITE, 0, 0, 1'b0);
		queue_cmd(ilse_pkg::CMD_WRITE, 0, 0, 1'b0);
		queue_cmd(ilse_pkg::CMD_PROBE, 1, 2, 1'b1);
		// sender holds off until the block is empty halfway through
		run_random(125);
		run_random(125);

		// largest lattice, largest coupling, receiver mostly stalling
		reconfigure(64, 64, 127);
		set_pace(0, 81);
		queue_cmd(ilse_pkg::CMD_FILL, 0, 0, 1'b0);
		run_random(300);

		reconfigure(5, 7, -1);
		set_pace(21, 21);
		queue_cmd(ilse_pkg::CMD_FILL, 0, 0, 1'b0);
		run_random(250);

		// zero rows acts as one, two columns: coinciding neighbours, no fill first
		reconfigure(0, 2, 3);
		set_pace(0, 0);
		run_random(150);

		// sizes above the bound clamp, zero coupling
		reconfigure(127, 100, 0);
		set_pace(21, 21);
		run_random(200);

		reconfigure(3, 64, -128);
		set_pace(81, 0);
		queue_cmd(ilse_pkg::CMD_FILL, 0, 0, 1'b0);
		run_random(200);

		reconfigure(64, 3, 1);
		set_pace(0, 81);
		queue_cmd(ilse_pkg::CMD_FILL, 0, 0, 1'b0);
		run_random(200);

		// catch any stray result transfer
		repeat (20) @(negedge clk);
		if (mismatch_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	// watchdog
	initial begin
		#1500000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule
